@@ rtl/core/picu_pkg.sv @@
`default_nettype none

package picu_pkg;

   // Item commands.
   typedef enum logic [1:0] {
      CMD_READ   = 2'd0,
      CMD_WRITE  = 2'd1,
      CMD_VRAM   = 2'd2,
      CMD_STATUS = 2'd3
   } command_type;

   // CPU visible register numbers.
   typedef enum logic [2:0] {
      REG_CTRL     = 3'd0,
      REG_MASK     = 3'd1,
      REG_STATUS   = 3'd2,
      REG_OAM_ADDR = 3'd3,
      REG_OAM_DATA = 3'd4,
      REG_SCROLL   = 3'd5,
      REG_ADDR     = 3'd6,
      REG_DATA     = 3'd7
   } reg_index_type;

   // Source of the byte returned to the CPU.
   typedef enum logic [2:0] {
      RD_NONE,
      RD_DIRECT,
      RD_SPRITE,
      RD_PALETTE,
      RD_BUFFER
   } rd_sel_type;

   localparam logic [5:0] PALETTE_PAGE = 6'h3F;

   // Result stage contents, captured when an item is accepted.
   typedef struct packed {
      rd_sel_type  rd_sel;
      logic [7:0]  direct;
      logic        buf_load;
      logic        pal_hit;
      logic        read_valid;
      logic [13:0] vram_address;
      logic        vram_write;
      logic        vram_read;
      logic [7:0]  vram_write_data;
      logic [14:0] current_address;
      logic [14:0] temp_address;
      logic [2:0]  fine_x;
      logic        nmi_request;
   } stage_type;

   // Palette index with the background color mirrors folded onto entries 0, 4, 8 and 12.
   function automatic logic [4:0] pal_index(input logic [4:0] a);
      logic [4:0] i;
      i = a;
      if (i[4] && (i[1:0] == 2'b00)) begin
         i[4] = 1'b0;
      end
      return i;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/picu_ram.sv @@
`default_nettype none

module picu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/picture_unit_cpu_register_port.sv @@
// CPU register port of a tile picture unit.
// Each input beat on the req_ channel carries one item: a CPU register read, a CPU
// register write, a byte of returned external video data, or a status update.
// Every accepted item produces exactly one result beat on the rsp_ channel, in order.
// Results carry the byte for a CPU read, any external video memory request made by a
// data port access, and the scroll registers V, T and fine X as they stand after the item.
// A beat accepted at one edge is offered on rsp_ after that edge. Throughput is one
// item per cycle while rsp_ready is high; the sprite memory and the palette are
// synchronous RAMs read at the accept edge, and their data is picked up by the single
// result stage. The result stage keeps its beat while rsp_ready is low; req_ready is
// high whenever that stage is empty or is being emptied in the same cycle, so a stalled
// receiver holds off the sender after at most one item.
// Reset clears all registers, the palette (through per-entry valid bits) and the
// result stage. The sprite memory is not cleared; an entry reads back only after it
// has been written. The read buffer is updated as each result leaves, so a read
// of the data port always sees the buffer as left by all earlier items.
`default_nettype none

module picture_unit_cpu_register_port #(
   parameter int SPRITE_BYTES    = 256,
   parameter int PALETTE_ENTRIES = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [2:0]  req_reg_index,
   input  wire logic [7:0]  req_write_data,
   input  wire logic [7:0]  req_vram_data,
   input  wire logic [2:0]  req_status_bits,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [7:0]  rsp_read_data,
   output logic             rsp_read_valid,
   output logic      [13:0] rsp_vram_address,
   output logic             rsp_vram_write,
   output logic             rsp_vram_read,
   output logic      [7:0]  rsp_vram_write_data,
   output logic      [14:0] rsp_current_address,
   output logic      [14:0] rsp_temp_address,
   output logic      [2:0]  rsp_fine_x,
   output logic             rsp_nmi_request
);

   import picu_pkg::*;

   localparam int SPR_AW = $clog2(SPRITE_BYTES);
   localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

   // Architectural registers.
   logic [7:0]        ctrl_ff,    ctrl_in;
   logic [7:0]        mask_ff,    mask_in;
   logic [2:0]        status_ff,  status_in;
   logic [SPR_AW-1:0] oam_ptr_ff, oam_ptr_in;
   logic [14:0]       v_ff,       v_in;
   logic [14:0]       t_ff,       t_in;
   logic [2:0]        fx_ff,      fx_in;
   logic              toggle_ff,  toggle_in;
   logic [7:0]        buffer_ff,  buffer_in;
   logic [PALETTE_ENTRIES-1:0] pal_valid_ff, pal_valid_in;

   // Result stage.
   logic      stage_valid_ff, stage_valid_in;
   stage_type stage_ff,       stage_in;

   logic              accept;
   logic              retire;
   logic [14:0]       v_step;
   logic              v_is_palette;
   logic [PAL_AW-1:0] pal_idx;

   logic       spr_wr_en, spr_rd_en;
   logic [7:0] spr_rdata;
   logic       pal_wr_en, pal_rd_en;
   logic [7:0] pal_rdata;
   logic [7:0] pal_value;

   assign retire    = stage_valid_ff && rsp_ready;
   assign req_ready = !stage_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign v_step       = v_ff + (ctrl_ff[2] ? 15'd32 : 15'd1);
   assign v_is_palette = (v_ff[13:8] == PALETTE_PAGE);
   assign pal_idx      = PAL_AW'(pal_index(v_ff[4:0]));

   // Decode of the accepted item: register updates, memory accesses and the result stage.
   always_comb begin
      ctrl_in      = ctrl_ff;
      mask_in      = mask_ff;
      status_in    = status_ff;
      oam_ptr_in   = oam_ptr_ff;
      v_in         = v_ff;
      t_in         = t_ff;
      fx_in        = fx_ff;
      toggle_in    = toggle_ff;
      pal_valid_in = pal_valid_ff;
      spr_wr_en    = 1'b0;
      spr_rd_en    = 1'b0;
      pal_wr_en    = 1'b0;
      pal_rd_en    = 1'b0;
      stage_in     = '0;
      stage_in.rd_sel = RD_NONE;

      case (command_type'(req_command))
         CMD_READ: begin
            stage_in.read_valid = 1'b1;
            case (reg_index_type'(req_reg_index))
               REG_STATUS: begin
                  stage_in.rd_sel = RD_DIRECT;
                  stage_in.direct = {status_ff, 5'b00000};
                  status_in       = {1'b0, status_ff[1:0]};
                  toggle_in       = 1'b0;
               end
               REG_OAM_DATA: begin
                  stage_in.rd_sel = RD_SPRITE;
                  spr_rd_en       = 1'b1;
               end
               REG_DATA: begin
                  stage_in.vram_address = v_ff[13:0];
                  if (v_is_palette) begin
                     stage_in.rd_sel  = RD_PALETTE;
                     stage_in.pal_hit = pal_valid_ff[pal_idx];
                     pal_rd_en        = 1'b1;
                  end else begin
                     stage_in.rd_sel    = RD_BUFFER;
                     stage_in.vram_read = 1'b1;
                  end
                  v_in = v_step;
               end
               default: begin
               end
            endcase
         end
         CMD_WRITE: begin
            case (reg_index_type'(req_reg_index))
               REG_CTRL: begin
                  ctrl_in      = req_write_data;
                  t_in[11:10]  = req_write_data[1:0];
               end
               REG_MASK: begin
                  mask_in = req_write_data;
               end
               REG_OAM_ADDR: begin
                  oam_ptr_in = SPR_AW'(req_write_data);
               end
               REG_OAM_DATA: begin
                  spr_wr_en  = 1'b1;
                  oam_ptr_in = oam_ptr_ff + 1'b1;
               end
               REG_SCROLL: begin
                  if (toggle_ff) begin
                     t_in[9:5]   = req_write_data[7:3];
                     t_in[14:12] = req_write_data[2:0];
                  end else begin
                     t_in[4:0] = req_write_data[7:3];
                     fx_in     = req_write_data[2:0];
                  end
                  toggle_in = !toggle_ff;
               end
               REG_ADDR: begin
                  if (toggle_ff) begin
                     t_in = {t_ff[14:8], req_write_data};
                     v_in = {t_ff[14:8], req_write_data};
                  end else begin
                     t_in = {1'b0, req_write_data[5:0], t_ff[7:0]};
                  end
                  toggle_in = !toggle_ff;
               end
               REG_DATA: begin
                  stage_in.vram_address = v_ff[13:0];
                  if (v_is_palette) begin
                     pal_wr_en             = 1'b1;
                     pal_valid_in[pal_idx] = 1'b1;
                  end else begin
                     stage_in.vram_write      = 1'b1;
                     stage_in.vram_write_data = req_write_data;
                  end
                  v_in = v_step;
               end
               default: begin
               end
            endcase
         end
         CMD_VRAM: begin
            stage_in.buf_load = 1'b1;
            stage_in.direct   = req_vram_data;
         end
         CMD_STATUS: begin
            stage_in.nmi_request = req_status_bits[2] && !status_ff[2] && ctrl_ff[7];
            status_in            = req_status_bits;
         end
         default: begin
         end
      endcase

      stage_in.current_address = v_in;
      stage_in.temp_address    = t_in;
      stage_in.fine_x          = fx_in;

      stage_valid_in = accept || (stage_valid_ff && !rsp_ready);
   end

   // A palette entry that was never written since reset reads as zero.
   assign pal_value = stage_ff.pal_hit ? pal_rdata : 8'h00;

   // The read buffer follows the items in order as their results leave.
   always_comb begin
      buffer_in = buffer_ff;
      if (retire) begin
         if (stage_ff.rd_sel == RD_PALETTE) begin
            buffer_in = pal_value;
         end else if (stage_ff.buf_load) begin
            buffer_in = stage_ff.direct;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff        <= '0;
         mask_ff        <= '0;
         status_ff      <= '0;
         oam_ptr_ff     <= '0;
         v_ff           <= '0;
         t_ff           <= '0;
         fx_ff          <= '0;
         toggle_ff      <= 1'b0;
         pal_valid_ff   <= '0;
         buffer_ff      <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            ctrl_ff      <= ctrl_in;
            mask_ff      <= mask_in;
            status_ff    <= status_in;
            oam_ptr_ff   <= oam_ptr_in;
            v_ff         <= v_in;
            t_ff         <= t_in;
            fx_ff        <= fx_in;
            toggle_ff    <= toggle_in;
            pal_valid_ff <= pal_valid_in;
         end
         buffer_ff      <= buffer_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   // Sprite memory: written and read at the pointer; read data is held while stalled.
   picu_ram #(
      .WIDTH (8),
      .DEPTH (SPRITE_BYTES)
   ) u_sprite_ram (
      .clock   (clock),
      .wr_en   (accept && spr_wr_en),
      .wr_addr (oam_ptr_ff),
      .wr_data (req_write_data),
      .rd_en   (accept && spr_rd_en),
      .rd_addr (oam_ptr_ff),
      .rd_data (spr_rdata)
   );

   // Palette store, addressed through the mirrored index of V.
   picu_ram #(
      .WIDTH (8),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette_ram (
      .clock   (clock),
      .wr_en   (accept && pal_wr_en),
      .wr_addr (pal_idx),
      .wr_data (req_write_data),
      .rd_en   (accept && pal_rd_en),
      .rd_addr (pal_idx),
      .rd_data (pal_rdata)
   );

   always_comb begin
      case (stage_ff.rd_sel)
         RD_DIRECT:  rsp_read_data = stage_ff.direct;
         RD_SPRITE:  rsp_read_data = spr_rdata;
         RD_PALETTE: rsp_read_data = pal_value;
         RD_BUFFER:  rsp_read_data = buffer_ff;
         default:    rsp_read_data = 8'h00;
      endcase
   end

   assign rsp_valid           = stage_valid_ff;
   assign rsp_read_valid      = stage_ff.read_valid;
   assign rsp_vram_address    = stage_ff.vram_address;
   assign rsp_vram_write      = stage_ff.vram_write;
   assign rsp_vram_read       = stage_ff.vram_read;
   assign rsp_vram_write_data = stage_ff.vram_write_data;
   assign rsp_current_address = stage_ff.current_address;
   assign rsp_temp_address    = stage_ff.temp_address;
   assign rsp_fine_x          = stage_ff.fine_x;
   assign rsp_nmi_request     = stage_ff.nmi_request;

   // The mask register is kept for the rendering side and is not visible here.
   logic unused_mask;
   assign unused_mask = ^mask_ff;

endmodule

`default_nettype wire

@@ rtl/core/picu_checker.sv @@
`default_nettype none

module picu_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_read_data,
   input wire logic        rsp_read_valid,
   input wire logic        rsp_vram_write,
   input wire logic        rsp_vram_read,
   input wire logic [7:0]  rsp_vram_write_data,
   input wire logic [14:0] rsp_current_address
);

   // No result may be offered in the cycle after reset.
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

   // A stalled beat keeps its read byte and address.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
         && $stable(rsp_current_address))
      else $error("stalled beat changed");

   // An external write never comes with a read request or a CPU read answer.
   a_write_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_vram_write |-> !rsp_vram_read && !rsp_read_valid)
      else $error("external write mixed with a read");

   // Write data and read data are zero unless their request is present.
   a_idle_bytes_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_vram_write || rsp_vram_write_data == 8'h00)
         && (rsp_read_valid || rsp_read_data == 8'h00))
      else $error("unused byte is not zero");

endmodule

bind picture_unit_cpu_register_port picu_checker u_picu_checker (.*);

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the CPU register port of the tile picture unit.
// A queue of bus items is built at time zero, and a clocked driver feeds it into the req_
// channel in bursts with random gaps. A monitor on the rising edge predicts the result of
// every accepted request beat. It checks every result beat against the oldest prediction.
module tb;
   import picu_pkg::*;

   localparam int CLOCK_HALF   = 5;
   localparam int RESET_CYCLES = 8;
   localparam int RANDOM_ITEMS = 360;
   localparam int IDLE_LIMIT   = 2000;
   localparam int TAIL_CYCLES  = 8;
   localparam int REPORT_LIMIT = 10;

   // Upper address bits that select the palette page.
   localparam logic [5:0] PAL_PAGE = 6'h3F;

   // One bus item. A set hold bit marks a pause: the driver stops there until every
   // predicted result has come back, and the hold item itself is never driven.
   typedef struct packed {
      logic          hold;
      command_type   command;
      reg_index_type reg_index;
      logic [7:0]    write_data;
      logic [7:0]    vram_data;
      logic [2:0]    status_bits;
   } bus_item_type;

   // One result beat, in the order of the rsp_ ports.
   typedef struct packed {
      logic [7:0]  read_data;
      logic        read_valid;
      logic [13:0] vram_address;
      logic        vram_write;
      logic        vram_read;
      logic [7:0]  vram_write_data;
      logic [14:0] current_address;
      logic [14:0] temp_address;
      logic [2:0]  fine_x;
      logic        nmi_request;
   } port_result_type;

   typedef enum {READY_ALWAYS, READY_MOSTLY, READY_RARELY} ready_mode_type;
   typedef enum {STIM_VRAM, STIM_SCROLL, STIM_SPRITE, STIM_STATUS, STIM_NOISE} stim_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = '0;
   logic [2:0]  req_reg_index = '0;
   logic [7:0]  req_write_data = '0;
   logic [7:0]  req_vram_data = '0;
   logic [2:0]  req_status_bits = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic [7:0]  rsp_read_data;
   logic        rsp_read_valid;
   logic [13:0] rsp_vram_address;
   logic        rsp_vram_write;
   logic        rsp_vram_read;
   logic [7:0]  rsp_vram_write_data;
   logic [14:0] rsp_current_address;
   logic [14:0] rsp_temp_address;
   logic [2:0]  rsp_fine_x;
   logic        rsp_nmi_request;

   picture_unit_cpu_register_port i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_reg_index       (req_reg_index),
      .req_write_data      (req_write_data),
      .req_vram_data       (req_vram_data),
      .req_status_bits     (req_status_bits),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_read_data       (rsp_read_data),
      .rsp_read_valid      (rsp_read_valid),
      .rsp_vram_address    (rsp_vram_address),
      .rsp_vram_write      (rsp_vram_write),
      .rsp_vram_read       (rsp_vram_read),
      .rsp_vram_write_data (rsp_vram_write_data),
      .rsp_current_address (rsp_current_address),
      .rsp_temp_address    (rsp_temp_address),
      .rsp_fine_x          (rsp_fine_x),
      .rsp_nmi_request     (rsp_nmi_request)
   );

   // Bench bookkeeping.
   bus_item_type    bus_items[$];
   port_result_type port_results[$];
   int              items_total = 0;
   int              items_accepted = 0;
   int              failures = 0;
   int              quiet_cycles = 0;
   logic            req_taken = 1'b0;
   int              burst_left = 0;
   int              gap_left = 0;
   ready_mode_type  ready_mode = READY_ALWAYS;
   int              ready_phase = 0;

   // The generator follows the sprite pointer and which sprite entries hold data, so that
   // no read of a sprite entry that was never written is ever issued.
   logic [7:0]   sprite_ptr = '0;
   logic         sprite_written [256];

   // Predicted state of the register port, as it stands after reset.
   logic [7:0]   ctrl_q = '0;
   logic [7:0]   mask_q = '0;
   logic [2:0]   flags_q = '0;
   logic [7:0]   oam_ptr = '0;
   logic [7:0]   oam_mem [256];
   logic [7:0]   pal_mem [32];
   logic [14:0]  v_q = '0;
   logic [14:0]  t_q = '0;
   logic [2:0]   fx_q = '0;
   logic         toggle_q = 1'b0;
   logic [7:0]   rbuf_q = '0;

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   // The backdrop entries of the sprite half (0x10, 0x14, 0x18 and 0x1C) share storage
   // with the entries at 0x00, 0x04, 0x08 and 0x0C.
   function automatic logic [4:0] pal_slot(input logic [14:0] addr);
      return (addr[4] && addr[1:0] == 2'b00) ? {1'b0, addr[3:0]} : addr[4:0];
   endfunction

   // Works out the result beat of one item and advances the predicted state.
   function automatic port_result_type predict_access(input bus_item_type it);
      port_result_type r;
      logic [14:0]     step;
      r = '0;
      step = ctrl_q[2] ? 15'd32 : 15'd1;
      case (it.command)
         CMD_READ: begin
            r.read_valid = 1'b1;
            case (it.reg_index)
               REG_STATUS: begin
                  // Reading status drops vertical blank and rearms the first write.
                  r.read_data = {flags_q, 5'b00000};
                  flags_q[2] = 1'b0;
                  toggle_q = 1'b0;
               end
               REG_OAM_DATA: r.read_data = oam_mem[oam_ptr];
               REG_DATA: begin
                  r.vram_address = v_q[13:0];
                  if (v_q[13:8] == PAL_PAGE) begin
                     rbuf_q = pal_mem[pal_slot(v_q)];
                     r.read_data = rbuf_q;
                  end else begin
                     r.read_data = rbuf_q;
                     r.vram_read = 1'b1;
                  end
                  v_q = v_q + step;
               end
               default: ;
            endcase
         end
         CMD_WRITE: begin
            case (it.reg_index)
               REG_CTRL: begin
                  ctrl_q = it.write_data;
                  t_q[11:10] = it.write_data[1:0];
               end
               REG_MASK: mask_q = it.write_data;
               REG_OAM_ADDR: oam_ptr = it.write_data;
               REG_OAM_DATA: begin
                  oam_mem[oam_ptr] = it.write_data;
                  oam_ptr = oam_ptr + 8'd1;
               end
               REG_SCROLL: begin
                  if (toggle_q) begin
                     t_q[14:12] = it.write_data[2:0];
                     t_q[9:5] = it.write_data[7:3];
                  end else begin
                     t_q[4:0] = it.write_data[7:3];
                     fx_q = it.write_data[2:0];
                  end
                  toggle_q = !toggle_q;
               end
               REG_ADDR: begin
                  if (toggle_q) begin
                     t_q[7:0] = it.write_data;
                     v_q = t_q;
                  end else begin
                     t_q[14:8] = {1'b0, it.write_data[5:0]};
                  end
                  toggle_q = !toggle_q;
               end
               REG_DATA: begin
                  r.vram_address = v_q[13:0];
                  if (v_q[13:8] == PAL_PAGE) begin
                     pal_mem[pal_slot(v_q)] = it.write_data;
                  end else begin
                     r.vram_write = 1'b1;
                     r.vram_write_data = it.write_data;
                  end
                  v_q = v_q + step;
               end
               default: ;
            endcase
         end
         CMD_VRAM: rbuf_q = it.vram_data;
         CMD_STATUS: begin
            r.nmi_request = it.status_bits[2] && !flags_q[2] && ctrl_q[7];
            flags_q = it.status_bits;
         end
         default: ;
      endcase
      r.current_address = v_q;
      r.temp_address = t_q;
      r.fine_x = fx_q;
      return r;
   endfunction

   // Queues one item. A sprite data read at an entry that holds nothing yet is turned
   // into a write of the same byte, which fills that entry.
   task automatic push_item(input command_type c, input reg_index_type r,
                            input logic [7:0] wd, input logic [7:0] vd, input logic [2:0] sb);
      bus_item_type it;
      if (c == CMD_READ && r == REG_OAM_DATA && !sprite_written[sprite_ptr]) begin
         c = CMD_WRITE;
      end
      if (c == CMD_WRITE && r == REG_OAM_ADDR) begin
         sprite_ptr = wd;
      end
      if (c == CMD_WRITE && r == REG_OAM_DATA) begin
         sprite_written[sprite_ptr] = 1'b1;
         sprite_ptr = sprite_ptr + 8'd1;
      end
      it.hold = 1'b0;
      it.command = c;
      it.reg_index = r;
      it.write_data = wd;
      it.vram_data = vd;
      it.status_bits = sb;
      bus_items.push_back(it);
      items_total++;
   endtask

   // Fields that an item does not use still carry random bits.
   task automatic cpu_write(input reg_index_type r, input logic [7:0] wd);
      push_item(CMD_WRITE, r, wd, 8'($urandom), 3'($urandom));
   endtask

   task automatic cpu_read(input reg_index_type r);
      push_item(CMD_READ, r, 8'($urandom), 8'($urandom), 3'($urandom));
   endtask

   task automatic vram_return(input logic [7:0] vd);
      push_item(CMD_VRAM, reg_index_type'($urandom_range(0, 7)), 8'($urandom), vd,
                3'($urandom));
   endtask

   task automatic status_update(input logic [2:0] sb);
      push_item(CMD_STATUS, reg_index_type'($urandom_range(0, 7)), 8'($urandom),
                8'($urandom), sb);
   endtask

   task automatic pause_for_results();
      bus_item_type it;
      it = '0;
      it.hold = 1'b1;
      bus_items.push_back(it);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         failures++;
         if (failures <= REPORT_LIMIT) begin
            $display("mismatch in %s at %0t: expected %0h, got %0h", name, $realtime, want,
                     got);
         end
      end
   endtask

   // Request driver. A new beat is presented only once the previous one has gone, so
   // valid and payload hold steady until the handshake completes. After each burst the
   // driver draws a new burst length and a gap; a gap of zero runs bursts back to back.
   always @(negedge clock) begin : req_driver
      bus_item_type next_item;
      logic         next_valid;
      next_valid = req_valid && !req_taken;
      if (!reset && !next_valid) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
         end else if (bus_items.size() > 0) begin
            if (bus_items[0].hold) begin
               // Stand still until the block has handed back everything it owes.
               if (port_results.size() == 0) begin
                  void'(bus_items.pop_front());
               end
            end else begin
               next_item = bus_items.pop_front();
               req_command <= next_item.command;
               req_reg_index <= next_item.reg_index;
               req_write_data <= next_item.write_data;
               req_vram_data <= next_item.vram_data;
               req_status_bits <= next_item.status_bits;
               next_valid = 1'b1;
               if (burst_left > 1) begin
                  burst_left = burst_left - 1;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
      req_valid <= next_valid;
   end

   // Result side back pressure. The receiver switches between always ready, mostly
   // ready and mostly stalled, holding each pattern for a random stretch of cycles.
   always @(negedge clock) begin : rsp_stall
      if (ready_phase == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 2));
         ready_phase = $urandom_range(16, 64);
      end
      ready_phase = ready_phase - 1;
      case (ready_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
         default:      rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // Monitor. The result beat taken at this edge belongs to an earlier request, so it
   // is checked before the request beat of this edge is predicted.
   always @(posedge clock) begin : port_monitor
      bus_item_type    seen;
      port_result_type want;
      port_result_type got;
      logic            moved;
      req_taken = 1'b0;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            got = {rsp_read_data, rsp_read_valid, rsp_vram_address, rsp_vram_write,
                   rsp_vram_read, rsp_vram_write_data, rsp_current_address,
                   rsp_temp_address, rsp_fine_x, rsp_nmi_request};
            if (port_results.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT) begin
                  $display("result beat at %0t with nothing predicted", $realtime);
               end
            end else begin
               want = port_results.pop_front();
               check_field("read_data", 16'(want.read_data), 16'(got.read_data));
               check_field("read_valid", 16'(want.read_valid), 16'(got.read_valid));
               check_field("vram_address", 16'(want.vram_address), 16'(got.vram_address));
               check_field("vram_write", 16'(want.vram_write), 16'(got.vram_write));
               check_field("vram_read", 16'(want.vram_read), 16'(got.vram_read));
               check_field("vram_write_data", 16'(want.vram_write_data),
                           16'(got.vram_write_data));
               check_field("current_address", 16'(want.current_address),
                           16'(got.current_address));
               check_field("temp_address", 16'(want.temp_address), 16'(got.temp_address));
               check_field("fine_x", 16'(want.fine_x), 16'(got.fine_x));
               check_field("nmi_request", 16'(want.nmi_request), 16'(got.nmi_request));
            end
         end
         if (req_valid && req_ready) begin
            moved = 1'b1;
            req_taken = 1'b1;
            seen.hold = 1'b0;
            seen.command = command_type'(req_command);
            seen.reg_index = reg_index_type'(req_reg_index);
            seen.write_data = req_write_data;
            seen.vram_data = req_vram_data;
            seen.status_bits = req_status_bits;
            port_results.push_back(predict_access(seen));
            items_accepted++;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
      end
   end

   // Watchdog: a long stretch with no beat on either channel means the block is stuck.
   initial begin : watchdog
      while (quiet_cycles < IDLE_LIMIT) @(posedge clock);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      int            target;
      int            n;
      stim_kind_type kind;
      logic [7:0]    base;
      logic [7:0]    hi;

      for (int i = 0; i < 32; i++) pal_mem[i] = '0;
      for (int i = 0; i < 256; i++) sprite_written[i] = 1'b0;

      // Directed part. Status straight after reset, then reads of the write-only
      // registers, which answer zero, and a write to status, which is ignored.
      cpu_read(REG_STATUS);
      cpu_read(REG_CTRL);
      cpu_read(REG_MASK);
      cpu_read(REG_OAM_ADDR);
      cpu_read(REG_SCROLL);
      cpu_read(REG_ADDR);
      cpu_write(REG_STATUS, 8'hFF);
      cpu_write(REG_MASK, 8'hFF);
      // Interrupt on the rising edge of vertical blank only, rearmed by a status read.
      cpu_write(REG_CTRL, 8'h84);
      status_update(3'b100);
      status_update(3'b111);
      cpu_read(REG_STATUS);
      status_update(3'b100);
      cpu_write(REG_CTRL, 8'h00);
      status_update(3'b000);
      // High address byte 0xFF is masked to the palette page; then a mirrored backdrop.
      cpu_write(REG_ADDR, 8'hFF);
      cpu_write(REG_ADDR, 8'h00);
      cpu_write(REG_DATA, 8'hA5);
      cpu_write(REG_ADDR, 8'h3F);
      cpu_write(REG_ADDR, 8'h10);
      cpu_read(REG_DATA);
      // External reads go through the buffer; a return with no read pending still loads it.
      cpu_write(REG_ADDR, 8'h20);
      cpu_write(REG_ADDR, 8'h00);
      cpu_read(REG_DATA);
      vram_return(8'h5A);
      cpu_read(REG_DATA);
      cpu_write(REG_DATA, 8'hFF);
      vram_return(8'h00);
      // Sprite pointer wraps from the last entry back to the first.
      cpu_write(REG_OAM_ADDR, 8'hFF);
      cpu_write(REG_OAM_DATA, 8'hC3);
      cpu_write(REG_OAM_ADDR, 8'hFF);
      cpu_read(REG_OAM_DATA);
      // Load V with all ones through the scroll writes, then step it past the top.
      cpu_write(REG_ADDR, 8'h3F);
      cpu_write(REG_SCROLL, 8'hFF);
      cpu_write(REG_SCROLL, 8'hFF);
      cpu_write(REG_ADDR, 8'hFF);
      cpu_read(REG_DATA);
      cpu_write(REG_CTRL, 8'h04);
      cpu_write(REG_DATA, 8'h00);
      pause_for_results();

      // Random part, built mostly from well formed register sequences.
      target = items_total + RANDOM_ITEMS;
      while (items_total < target) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: kind = STIM_VRAM;
            4:          kind = STIM_SCROLL;
            5, 6:       kind = STIM_SPRITE;
            7:          kind = STIM_STATUS;
            default:    kind = STIM_NOISE;
         endcase
         case (kind)
            STIM_VRAM: begin
               cpu_read(REG_STATUS);
               if ($urandom_range(0, 2) == 0) begin
                  cpu_write(REG_CTRL, 8'($urandom));
               end
               hi = 8'($urandom);
               if ($urandom_range(0, 2) == 0) begin
                  hi[5:0] = PAL_PAGE;
               end
               cpu_write(REG_ADDR, hi);
               cpu_write(REG_ADDR, 8'($urandom));
               n = $urandom_range(1, 8);
               repeat (n) begin
                  case ($urandom_range(0, 2))
                     0: cpu_write(REG_DATA, 8'($urandom));
                     1: begin
                        cpu_read(REG_DATA);
                        if ($urandom_range(0, 3) != 0) begin
                           vram_return(8'($urandom));
                        end
                     end
                     default: vram_return(8'($urandom));
                  endcase
               end
            end
            STIM_SCROLL: begin
               cpu_read(REG_STATUS);
               cpu_write(REG_SCROLL, 8'($urandom));
               cpu_write(REG_SCROLL, 8'($urandom));
            end
            STIM_SPRITE: begin
               base = 8'($urandom);
               n = $urandom_range(1, 6);
               cpu_write(REG_OAM_ADDR, base);
               repeat (n) cpu_write(REG_OAM_DATA, 8'($urandom));
               cpu_write(REG_OAM_ADDR, base);
               repeat (n) begin
                  cpu_read(REG_OAM_DATA);
                  if ($urandom_range(0, 1) == 0) begin
                     cpu_read(REG_OAM_DATA);
                  end
                  cpu_write(REG_OAM_DATA, 8'($urandom));
               end
            end
            STIM_STATUS: begin
               base = 8'($urandom);
               base[7] = ($urandom_range(0, 3) != 0);
               cpu_write(REG_CTRL, base);
               n = $urandom_range(1, 5);
               repeat (n) begin
                  if ($urandom_range(0, 2) == 0) begin
                     cpu_read(REG_STATUS);
                  end else begin
                     status_update(3'($urandom));
                  end
               end
            end
            default: begin
               n = $urandom_range(1, 4);
               repeat (n) begin
                  push_item(command_type'($urandom_range(0, 3)),
                            reg_index_type'($urandom_range(0, 7)), 8'($urandom),
                            8'($urandom), 3'($urandom));
               end
            end
         endcase
         if ($urandom_range(0, 24) == 0) begin
            pause_for_results();
         end
      end

      // Hold reset, then release it on a falling edge.
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (items_accepted != items_total || port_results.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (port_results.size() != 0) begin
         failures++;
      end
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
